/* design/glp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glp_pkg
// Shared types and constants of the gesture loop playback block.
// ----------------------------------------------------------------------------
package glp_pkg;

   localparam int DIV_NUM_W = 48;
   localparam int DIV_DEN_W = 40;

   localparam logic [15:0] SPEED_FLOOR = 16'd13;

   typedef enum logic [1:0] {
      CMD_CLEAR    = 2'd0,
      CMD_APPEND   = 2'd1,
      CMD_FINALIZE = 2'd2,
      CMD_QUERY    = 2'd3
   } cmd_type;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_IDLE = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;

   localparam logic [1:0] CSR_SPEED     = 2'd0;
   localparam logic [1:0] CSR_RANGE_EN  = 2'd1;
   localparam logic [1:0] CSR_RANGE_LOW = 2'd2;
   localparam logic [1:0] CSR_RANGE_HI  = 2'd3;

   typedef struct packed {
      logic        grab;
      logic [31:0] stamp;
      logic [31:0] value;
   } entry_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

/* design/glp_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glp_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module glp_divider import glp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output div_stat_type         stat,
   output logic [DIV_NUM_W-1:0] quot,
   output logic [DIV_DEN_W-1:0] rem
);

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic [DIV_NUM_W-1:0] quot_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_DEN_W:0]   rem_sh;
   logic                 ge;
   logic [DIV_DEN_W:0]   rem_in;

   always_comb begin
      rem_sh = {rem_ff, quot_ff[DIV_NUM_W-1]};
      ge     = rem_sh >= {1'b0, den_ff};
      rem_in = ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == CNT_W'(DIV_NUM_W - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            quot_ff <= num;
            rem_ff  <= '0;
            den_ff  <= den;
         end else if (busy_ff) begin
            quot_ff <= {quot_ff[DIV_NUM_W-2:0], ge};
            rem_ff  <= rem_in[DIV_DEN_W-1:0];
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_NUM_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = quot_ff;
   assign rem       = rem_ff;

endmodule

/* design/gesture_loop_playback.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gesture_loop_playback
// Records a trace of breakpoints in a memory and plays it back as a loop.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  req_*     in         tdata: sample_value, sample_time, now_time; tuser: command, new_grab
//  rsp_*     out        tdata: play_value; tuser: status
//  csr_*     in         register writes, index 0..3
//
//  Clear and append go straight to the output state; finalize of a new loop scans
//  its N samples for their min and max. A query's time is set by the entry scan
//  through the one memory read port and by the shared bit-serial divider.
//  Reset is synchronous and empties the store; there is no clearing pass.
//  One word is worked on at a time; a result waits in the output register.
// ----------------------------------------------------------------------------
module gesture_loop_playback import glp_pkg::*; #(
   parameter int MAX_SAMPLES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // sample_value, sample_time, now_time
   input  logic [2:0]  req_tuser,   // command, new_grab
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // play_value
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int CW = $clog2(MAX_SAMPLES + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_FSCAN, ST_QFIRST, ST_QLAST, ST_QMOD, ST_QSCAN, ST_QFRAC,
      ST_QMUL, ST_QADD, ST_REMAP, ST_QNORM, ST_RMUL, ST_RADD, ST_OUT
   } state_type;

   state_type state_ff;

   entry_type mem [MAX_SAMPLES];
   entry_type rdata_ff;
   logic [AW-1:0] raddr;
   logic          mem_we;
   logic [AW-1:0] waddr;
   entry_type     wentry;

   logic [15:0]        speed_ff;
   logic               ren_ff;
   logic signed [31:0] rlow_ff;
   logic signed [31:0] rhigh_ff;

   logic [CW-1:0]      count_ff;
   logic               active_ff;
   logic [31:0]        start_ff;
   logic signed [31:0] min_ff;
   logic signed [31:0] max_ff;

   logic [31:0]        now_ff;
   logic [CW-1:0]      idx_ff;
   logic [31:0]        first_ff;
   logic signed [31:0] raw_ff;
   logic signed [49:0] el_ff;
   logic [39:0]        dur_ff;
   logic [40:0]        target_ff;
   entry_type          prev_ff;
   entry_type          seg_ff;
   logic [16:0]        f_ff;
   logic signed [50:0] prod_ff;
   logic [1:0]         status_ff;
   logic [31:0]        value_ff;

   logic               rsp_valid_ff;
   logic [31:0]        rsp_data_ff;
   logic [1:0]         rsp_stat_ff;

   logic                 div_go;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   div_stat_type         div_stat;
   logic [DIV_NUM_W-1:0] div_quot;
   logic [DIV_DEN_W-1:0] div_rem;

   logic               accept;
   cmd_type            cmd;
   logic [CW-1:0]      eff_count;
   logic [15:0]        spd;
   logic signed [32:0] tdiff;
   logic [49:0]        el_abs;
   logic [31:0]        last_span;
   logic               found;
   logic [40:0]        d_off;
   logic               seg_hold;
   logic [39:0]        r_mod;
   logic signed [32:0] seg_dv;
   logic signed [32:0] rng_dv;
   logic [31:0]        raw_off;
   logic [31:0]        mm_span;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign cmd        = cmd_type'(req_tuser[1:0]);
   assign eff_count  = active_ff ? '0 : count_ff;

   always_comb begin
      spd       = (speed_ff < SPEED_FLOOR) ? SPEED_FLOOR : speed_ff;
      tdiff     = $signed({1'b0, now_ff}) - $signed({1'b0, start_ff});
      el_abs    = el_ff[49] ? 50'(-el_ff) : 50'(el_ff);
      last_span = rdata_ff.stamp - first_ff;
      found     = target_ff <= {1'b0, rdata_ff.stamp, 8'b0};
      d_off     = target_ff - {1'b0, prev_ff.stamp, 8'b0};
      seg_hold  = rdata_ff.grab || (rdata_ff.stamp <= prev_ff.stamp);
      r_mod     = (el_ff[49] && (div_rem != '0)) ? (dur_ff - div_rem) : div_rem;
      seg_dv    = $signed({seg_ff.value[31], seg_ff.value})
                - $signed({prev_ff.value[31], prev_ff.value});
      rng_dv    = $signed({rhigh_ff[31], rhigh_ff}) - $signed({rlow_ff[31], rlow_ff});
      raw_off   = raw_ff - min_ff;
      mm_span   = max_ff - min_ff;
   end

   always_comb begin
      case (state_ff)
         ST_FSCAN: raddr = AW'(idx_ff + 1'b1);
         ST_QFIRST: raddr = AW'(count_ff - 1'b1);
         ST_QMOD: raddr = AW'(1);
         ST_QSCAN: raddr = AW'(idx_ff + 1'b1);
         default: raddr = '0;
      endcase
   end

   always_comb begin
      div_go  = 1'b0;
      div_num = '0;
      div_den = '0;
      case (state_ff)
         ST_QLAST: begin
            div_go  = rdata_ff.stamp > first_ff;
            div_num = el_abs[DIV_NUM_W-1:0];
            div_den = {last_span, 8'b0};
         end
         ST_QSCAN: begin
            div_go  = found && !seg_hold;
            div_num = {d_off[39:0], 8'b0};
            div_den = {8'b0, rdata_ff.stamp - prev_ff.stamp};
         end
         ST_REMAP: begin
            div_go  = ren_ff && (max_ff > min_ff);
            div_num = {raw_off, 16'b0};
            div_den = {8'b0, mm_span};
         end
         default: begin
            div_go = 1'b0;
         end
      endcase
   end

   always_comb begin
      mem_we = accept && (cmd == CMD_APPEND) && (eff_count < CW'(MAX_SAMPLES));
      waddr  = eff_count[AW-1:0];
      wentry = '{grab: req_tuser[2], stamp: req_tdata[63:32], value: req_tdata[31:0]};
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wentry;
      end
      rdata_ff <= mem[raddr];
   end

   glp_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff     <= 16'd256;
         ren_ff       <= 1'b0;
         rlow_ff      <= 32'sd0;
         rhigh_ff     <= 32'sd65536;
         count_ff     <= '0;
         active_ff    <= 1'b0;
         start_ff     <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SPEED: speed_ff <= csr_wdata[15:0];
               CSR_RANGE_EN: ren_ff <= csr_wdata[0];
               CSR_RANGE_LOW: rlow_ff <= csr_wdata;
               CSR_RANGE_HI: rhigh_ff <= csr_wdata;
               default: ren_ff <= ren_ff;
            endcase
         end
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  now_ff   <= req_tdata[95:64];
                  value_ff <= '0;
                  case (cmd)
                     CMD_CLEAR: begin
                        count_ff  <= '0;
                        active_ff <= 1'b0;
                        status_ff <= STAT_OK;
                        state_ff  <= ST_OUT;
                     end
                     CMD_APPEND: begin
                        active_ff <= 1'b0;
                        state_ff  <= ST_OUT;
                        if (eff_count < CW'(MAX_SAMPLES)) begin
                           count_ff  <= eff_count + 1'b1;
                           status_ff <= STAT_OK;
                        end else begin
                           count_ff  <= eff_count;
                           status_ff <= STAT_FULL;
                        end
                     end
                     CMD_FINALIZE: begin
                        if (!active_ff && count_ff >= CW'(2)) begin
                           active_ff <= 1'b1;
                           start_ff  <= req_tdata[95:64];
                           idx_ff    <= '0;
                           status_ff <= STAT_OK;
                           state_ff  <= ST_FSCAN;
                        end else if (!active_ff) begin
                           count_ff  <= '0;
                           status_ff <= STAT_IDLE;
                           state_ff  <= ST_OUT;
                        end else begin
                           status_ff <= STAT_OK;
                           state_ff  <= ST_OUT;
                        end
                     end
                     default: begin
                        if (!active_ff || count_ff < CW'(2)) begin
                           status_ff <= STAT_IDLE;
                           state_ff  <= ST_OUT;
                        end else begin
                           status_ff <= STAT_OK;
                           state_ff  <= ST_QFIRST;
                        end
                     end
                  endcase
               end
            end
            ST_FSCAN: begin
               if (idx_ff == '0) begin
                  min_ff <= rdata_ff.value;
                  max_ff <= rdata_ff.value;
               end else begin
                  if ($signed(rdata_ff.value) < min_ff) min_ff <= rdata_ff.value;
                  if ($signed(rdata_ff.value) > max_ff) max_ff <= rdata_ff.value;
               end
               if (idx_ff == count_ff - 1'b1) begin
                  state_ff <= ST_OUT;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_QFIRST: begin
               first_ff <= rdata_ff.stamp;
               prev_ff  <= rdata_ff;
               el_ff    <= tdiff * $signed({1'b0, spd});
               state_ff <= ST_QLAST;
            end
            ST_QLAST: begin
               raw_ff <= rdata_ff.value;
               dur_ff <= {last_span, 8'b0};
               state_ff <= (rdata_ff.stamp > first_ff) ? ST_QMOD : ST_REMAP;
            end
            ST_QMOD: begin
               if (div_stat.done) begin
                  target_ff <= {1'b0, first_ff, 8'b0} + {1'b0, r_mod};
                  idx_ff    <= CW'(1);
                  state_ff  <= ST_QSCAN;
               end
            end
            ST_QSCAN: begin
               if (found) begin
                  seg_ff <= rdata_ff;
                  if (seg_hold) begin
                     raw_ff   <= prev_ff.value;
                     state_ff <= ST_REMAP;
                  end else begin
                     state_ff <= ST_QFRAC;
                  end
               end else begin
                  prev_ff <= rdata_ff;
                  if (idx_ff == count_ff - 1'b1) begin
                     state_ff <= ST_REMAP;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            ST_QFRAC: begin
               if (div_stat.done) begin
                  f_ff <= (div_quot > DIV_NUM_W'(65536)) ? 17'd65536 : div_quot[16:0];
                  state_ff <= ST_QMUL;
               end
            end
            ST_QMUL: begin
               prod_ff  <= $signed({1'b0, f_ff}) * seg_dv;
               state_ff <= ST_QADD;
            end
            ST_QADD: begin
               raw_ff   <= prev_ff.value + prod_ff[47:16];
               state_ff <= ST_REMAP;
            end
            ST_REMAP: begin
               if (!ren_ff) begin
                  value_ff <= raw_ff;
                  state_ff <= ST_OUT;
               end else if (max_ff > min_ff) begin
                  state_ff <= ST_QNORM;
               end else begin
                  value_ff <= rlow_ff;
                  state_ff <= ST_OUT;
               end
            end
            ST_QNORM: begin
               if (div_stat.done) begin
                  f_ff     <= div_quot[16:0];
                  state_ff <= ST_RMUL;
               end
            end
            ST_RMUL: begin
               prod_ff  <= $signed({1'b0, f_ff}) * rng_dv;
               state_ff <= ST_RADD;
            end
            ST_RADD: begin
               value_ff <= rlow_ff + prod_ff[47:16];
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= value_ff;
                  rsp_stat_ff  <= status_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_stat_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_SAMPLES)) else $error("sample count beyond store depth");

   a_active_count: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> count_ff >= CW'(2)) else $error("loop active with fewer than two samples");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_go |-> !div_stat.busy) else $error("divider started while busy");

endmodule
